>>> rtl/vid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vid_pkg: shared types and constants of the vertex index deduplicator
// Table geometry, hash constants, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package vid_pkg;

    // Table geometry. TABLE_SLOTS must be a power of two.
    localparam int MAX_VERTICES = 4096;
    localparam int TABLE_SLOTS  = 8192;
    localparam int SLOT_W       = $clog2(TABLE_SLOTS);
    localparam int NUM_W        = $clog2(MAX_VERTICES + 1);

    // Word fields.
    localparam int IDX_W        = 16;
    localparam int KEY_W        = 3 * IDX_W;
    localparam int VNUM_W       = 12;
    localparam int OUT_TDATA_W  = 16;
    localparam int MEM_W        = 1 + VNUM_W + KEY_W;

    // Multiplicative hash: home slot is bits [32 +: SLOT_W] of key * HASH_MULT.
    localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;
    localparam int          HALF_W    = 32;
    localparam int          HASH_W    = HALF_W + SLOT_W;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [VNUM_W-1:0] vnum_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH0,
        ST_HASH1,
        ST_HASH2,
        ST_HASH3,
        ST_READ,
        ST_CHECK,
        ST_INSERT,
        ST_PUSH
    } state_t;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [1:0] {
        MUL_LO_LO,
        MUL_LO_HI,
        MUL_HI_LO
    } mul_sel_t;

    typedef enum logic [1:0] {
        RES_HIT,
        RES_NEW,
        RES_FULL
    } res_kind_t;

    typedef struct packed {
        logic      clear_wr;
        logic      load_key;
        mul_sel_t  mul_sel;
        logic      acc_init;
        logic      acc_add;
        logic      set_home;
        logic      probe_clr;
        logic      advance;
        logic      ins_wr;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hit;
        logic empty;
        logic probe_last;
        logic num_full;
    } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/vertex_index_dedup_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_index_dedup_top: vertex deduplication hash map
// Maps each face corner's (position, texcoord, normal) index triple to a
// dense vertex number, assigning new numbers to triples seen for the first
// time.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Word contents (lowest bit first)
//   s_axis    in    tdata: position_index[15:0], texcoord_index[15:0],
//                          normal_index[15:0]
//   m_axis    out   tdata: vertex_number[11:0], 4 zero bits
//                   tuser: is_new, table_full
//
// An accepted input word runs through the hash steps, the first slot read,
// one check per table probe, an insert when a new triple is stored, and the
// push to the output word register before the next word can be accepted.
// The hash steps HASH0 to HASH3 share one 32x32 multiplier; each probe is
// one read on the slot memory's read port. After reset the block clears all
// TABLE_SLOTS (8192) slots, one slot per cycle; s_axis_tready stays low during this pass.
// A finished result waits in the output word register, so a new input word
// is accepted while m_axis is stalled; the block only holds when a second
// result is ready before the first was taken.
// ----------------------------------------------------------------------------
module vertex_index_dedup_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // position_index, texcoord_index, normal_index
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // vertex_number, zero padding
    output logic [1:0]       m_axis_tuser   // is_new, table_full
);

    vid_pkg::ctrl_cmd_t  cmd;
    vid_pkg::dp_status_t status;
    vid_pkg::vnum_t      out_number;
    logic                out_new;
    logic                out_full;

    // The key is the three indices concatenated, position in the low bits,
    // which is exactly the layout of the input word.
    vid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    vid_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_key     (s_axis_tdata),
        .out_number (out_number),
        .out_new    (out_new),
        .out_full   (out_full)
    );

    assign m_axis_tdata = {{(vid_pkg::OUT_TDATA_W - vid_pkg::VNUM_W){1'b0}}, out_number};
    assign m_axis_tuser = {out_full, out_new};

    // A result never claims both a fresh number and a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result marked both new and full");

    // A full-table result carries vertex number zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0))
    else $error("full-table result with nonzero vertex number");

    // One word at a time: the block is busy right after taking a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

    // Stores and the clearing pass never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ins_wr && cmd.clear_wr))
    else $error("insert during clearing pass");

endmodule
`default_nettype wire

>>> rtl/vid_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vid_dpath: datapath of the vertex index deduplicator
// Key register, shared hash multiplier, slot memory with one read and one
// write port, probe pointer, number allocator and result registers.
// ----------------------------------------------------------------------------
module vid_dpath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vid_pkg::ctrl_cmd_t cmd,
    output vid_pkg::dp_status_t     status,
    input  wire vid_pkg::key_t      in_key,
    output vid_pkg::vnum_t          out_number,
    output logic                    out_new,
    output logic                    out_full
);

    // Slot memory word: {valid, number, key}.
    logic [vid_pkg::MEM_W-1:0] mem [vid_pkg::TABLE_SLOTS];
    logic [vid_pkg::MEM_W-1:0] rd_data_reg;
    logic [vid_pkg::MEM_W-1:0] wr_data;
    vid_pkg::slot_t            rd_addr;
    vid_pkg::slot_t            wr_addr;
    logic                      wr_en;

    vid_pkg::key_t               key_reg;
    logic [63:0]                 prod_reg;
    logic [63:0]                 prod_next;
    logic [vid_pkg::HALF_W-1:0]  mul_a;
    logic [vid_pkg::HALF_W-1:0]  mul_b;
    logic [vid_pkg::HASH_W-1:0]  acc_reg;
    logic [vid_pkg::HASH_W-1:0]  acc_next;
    logic [vid_pkg::HASH_W-1:0]  prod_shifted;

    vid_pkg::slot_t            idx_reg;
    vid_pkg::slot_t            idx_inc;
    vid_pkg::slot_t            probe_cnt_reg;
    vid_pkg::slot_t            clr_cnt_reg;
    logic [vid_pkg::NUM_W-1:0] next_number_reg;

    vid_pkg::vnum_t res_number_reg;
    logic           res_new_reg;
    logic           res_full_reg;
    vid_pkg::vnum_t out_number_reg;
    logic           out_new_reg;
    logic           out_full_reg;

    logic           rd_valid;
    vid_pkg::vnum_t rd_number;
    vid_pkg::key_t  rd_key;

    // Shared 32x32 multiplier, operands picked per hash step.
    always_comb
    begin
        unique case (cmd.mul_sel)
            vid_pkg::MUL_LO_LO:
            begin
                mul_a = key_reg[vid_pkg::HALF_W-1:0];
                mul_b = vid_pkg::HASH_MULT[vid_pkg::HALF_W-1:0];
            end
            vid_pkg::MUL_LO_HI:
            begin
                mul_a = key_reg[vid_pkg::HALF_W-1:0];
                mul_b = vid_pkg::HASH_MULT[63:vid_pkg::HALF_W];
            end
            vid_pkg::MUL_HI_LO:
            begin
                mul_a = vid_pkg::HALF_W'(key_reg[vid_pkg::KEY_W-1:vid_pkg::HALF_W]);
                mul_b = vid_pkg::HASH_MULT[vid_pkg::HALF_W-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next    = 64'(mul_a) * 64'(mul_b);
    // Cross products land 32 bits up; only the bits up to the home slot count.
    assign prod_shifted = {prod_reg[vid_pkg::SLOT_W-1:0], {vid_pkg::HALF_W{1'b0}}};
    assign acc_next     = cmd.acc_init ? prod_reg[vid_pkg::HASH_W-1:0]
                                       : acc_reg + prod_shifted;

    assign idx_inc = idx_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load_key)
        begin
            key_reg <= in_key;
        end
        if (cmd.acc_init || cmd.acc_add)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.set_home)
        begin
            idx_reg <= acc_next[vid_pkg::HASH_W-1:vid_pkg::HALF_W];
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_inc;
        end
    end

    // Slot memory.
    assign rd_addr = cmd.advance ? idx_inc : idx_reg;
    assign wr_en   = cmd.clear_wr || cmd.ins_wr;
    assign wr_addr = cmd.clear_wr ? clr_cnt_reg : idx_reg;
    assign wr_data = cmd.clear_wr ? '0
                                  : {1'b1, vid_pkg::VNUM_W'(next_number_reg), key_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_valid  = rd_data_reg[vid_pkg::MEM_W-1];
    assign rd_number = rd_data_reg[vid_pkg::MEM_W-2:vid_pkg::KEY_W];
    assign rd_key    = rd_data_reg[vid_pkg::KEY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg     <= '0;
            probe_cnt_reg   <= '0;
            next_number_reg <= '0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.probe_clr)
            begin
                probe_cnt_reg <= '0;
            end
            else if (cmd.advance)
            begin
                probe_cnt_reg <= probe_cnt_reg + 1'b1;
            end
            if (cmd.ins_wr)
            begin
                next_number_reg <= next_number_reg + 1'b1;
            end
        end
    end

    // Result and output words.
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            unique case (cmd.res_kind)
                vid_pkg::RES_HIT:
                begin
                    res_number_reg <= rd_number;
                    res_new_reg    <= 1'b0;
                    res_full_reg   <= 1'b0;
                end
                vid_pkg::RES_NEW:
                begin
                    res_number_reg <= vid_pkg::VNUM_W'(next_number_reg);
                    res_new_reg    <= 1'b1;
                    res_full_reg   <= 1'b0;
                end
                vid_pkg::RES_FULL:
                begin
                    res_number_reg <= '0;
                    res_new_reg    <= 1'b0;
                    res_full_reg   <= 1'b1;
                end
                default:
                begin
                    res_number_reg <= '0;
                    res_new_reg    <= 1'b0;
                    res_full_reg   <= 1'b1;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_number_reg <= res_number_reg;
            out_new_reg    <= res_new_reg;
            out_full_reg   <= res_full_reg;
        end
    end

    assign status.clear_last = (clr_cnt_reg == vid_pkg::SLOT_W'(vid_pkg::TABLE_SLOTS - 1));
    assign status.empty      = !rd_valid;
    assign status.hit        = rd_valid && (rd_key == key_reg);
    assign status.probe_last = (probe_cnt_reg == vid_pkg::SLOT_W'(vid_pkg::TABLE_SLOTS - 1));
    assign status.num_full   = (next_number_reg >= vid_pkg::NUM_W'(vid_pkg::MAX_VERTICES));

    assign out_number = out_number_reg;
    assign out_new    = out_new_reg;
    assign out_full   = out_full_reg;

endmodule
`default_nettype wire

>>> rtl/vid_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vid_ctrl: controller of the vertex index deduplicator
// Sequences the clearing pass, the hash steps, the probe loop, the insert
// and the hand-off to the output word register.
// ----------------------------------------------------------------------------
module vid_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire vid_pkg::dp_status_t status,
    output vid_pkg::ctrl_cmd_t       cmd
);

    vid_pkg::state_t state_reg;
    vid_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vid_pkg::ST_CLEAR:  if (status.clear_last) state_next = vid_pkg::ST_IDLE;
            vid_pkg::ST_IDLE:   if (in_valid) state_next = vid_pkg::ST_HASH0;
            vid_pkg::ST_HASH0:  state_next = vid_pkg::ST_HASH1;
            vid_pkg::ST_HASH1:  state_next = vid_pkg::ST_HASH2;
            vid_pkg::ST_HASH2:  state_next = vid_pkg::ST_HASH3;
            vid_pkg::ST_HASH3:  state_next = vid_pkg::ST_READ;
            vid_pkg::ST_READ:   state_next = vid_pkg::ST_CHECK;
            vid_pkg::ST_CHECK:
            begin
                priority if (status.empty)
                begin
                    state_next = status.num_full ? vid_pkg::ST_PUSH : vid_pkg::ST_INSERT;
                end
                else if (status.hit || status.probe_last)
                begin
                    state_next = vid_pkg::ST_PUSH;
                end
                else
                begin
                    state_next = vid_pkg::ST_CHECK;
                end
            end
            vid_pkg::ST_INSERT: state_next = vid_pkg::ST_PUSH;
            vid_pkg::ST_PUSH:   if (out_free) state_next = vid_pkg::ST_IDLE;
            default:            state_next = vid_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = vid_pkg::MUL_LO_LO;
        cmd.res_kind = vid_pkg::RES_FULL;
        unique case (state_reg)
            vid_pkg::ST_CLEAR:  cmd.clear_wr = 1'b1;
            vid_pkg::ST_IDLE:   cmd.load_key = in_valid;
            vid_pkg::ST_HASH0:  cmd.mul_sel  = vid_pkg::MUL_LO_LO;
            vid_pkg::ST_HASH1:
            begin
                cmd.mul_sel  = vid_pkg::MUL_LO_HI;
                cmd.acc_init = 1'b1;
            end
            vid_pkg::ST_HASH2:
            begin
                cmd.mul_sel = vid_pkg::MUL_HI_LO;
                cmd.acc_add = 1'b1;
            end
            vid_pkg::ST_HASH3:
            begin
                cmd.acc_add  = 1'b1;
                cmd.set_home = 1'b1;
            end
            vid_pkg::ST_READ:   cmd.probe_clr = 1'b1;
            vid_pkg::ST_CHECK:
            begin
                priority if (status.empty)
                begin
                    cmd.res_load = status.num_full;
                    cmd.res_kind = vid_pkg::RES_FULL;
                end
                else if (status.hit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = vid_pkg::RES_HIT;
                end
                else if (status.probe_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = vid_pkg::RES_FULL;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            vid_pkg::ST_INSERT:
            begin
                cmd.ins_wr   = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_kind = vid_pkg::RES_NEW;
            end
            vid_pkg::ST_PUSH:   cmd.out_load = out_free;
            default:            cmd.clear_wr = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vid_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == vid_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vertex_index_dedup_top
// Drives index triples into the deduplicator over the input stream and checks
// every result word against a software copy of the open-addressed table. The
// run covers directed corners, random traffic rich in repeats, near-misses and
// probe collisions, and a long output stall.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_SLOTS  = vid_pkg::TABLE_SLOTS;
    localparam int MAX_VERTICES = vid_pkg::MAX_VERTICES;
    localparam int SLOT_BITS    = $clog2(TABLE_SLOTS);
    localparam logic [63:0] GOLDEN_MULT = 64'h9E37_79B9_7F4A_7C15;

    localparam int RANDOM_CORNERS = 480;
    localparam int WRAP_CORNERS   = 3;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int RUN_LIMIT      = 400000;

    typedef vid_pkg::key_t  key_t;
    typedef vid_pkg::vnum_t vnum_t;

    // One result word in decoded form.
    typedef struct packed {
        vnum_t vertex_number;
        logic  is_new;
        logic  table_full;
    } corner_result_t;

    // Software copy of the vertex map. Every accepted triple is run through
    // the same linear-probe lookup as the block, and the outcome is queued
    // until the matching result word comes out.
    class vertex_map_scoreboard;
        bit             slot_used [TABLE_SLOTS];
        key_t           slot_tag  [TABLE_SLOTS];
        vnum_t          slot_vnum [TABLE_SLOTS];
        int unsigned    next_vertex = 0;
        corner_result_t results_due [$];
        key_t           stored_keys [$];
        int             mismatch_count = 0;
        int             words_seen = 0;

        function int unsigned home_slot(key_t key);
            logic [63:0] prod;
            prod = {16'd0, key} * GOLDEN_MULT;
            return prod[32 +: SLOT_BITS];
        endfunction

        // Returns the slot holding the key (hit set) or the first free slot on
        // its probe chain, or -1 if every slot is taken.
        function int find_slot(key_t key, output bit hit);
            int unsigned slot;
            int          n;
            hit  = 1'b0;
            slot = home_slot(key);
            for (n = 0; n < TABLE_SLOTS; n++)
            begin
                if (!slot_used[slot])
                    return slot;
                if (slot_tag[slot] == key)
                begin
                    hit = 1'b1;
                    return slot;
                end
                slot = (slot + 1) % TABLE_SLOTS;
            end
            return -1;
        endfunction

        function void note_corner(key_t key);
            corner_result_t r;
            int             slot;
            bit             hit;
            slot = find_slot(key, hit);
            r    = '0;
            if (hit)
            begin
                r.vertex_number = slot_vnum[slot];
            end
            else if (slot < 0 || next_vertex >= MAX_VERTICES)
            begin
                r.table_full = 1'b1;
            end
            else
            begin
                slot_used[slot] = 1'b1;
                slot_tag[slot]  = key;
                slot_vnum[slot] = vnum_t'(next_vertex);
                r.vertex_number = vnum_t'(next_vertex);
                r.is_new        = 1'b1;
                next_vertex++;
                stored_keys.insert(stored_keys.size(), key);
            end
            results_due.insert(results_due.size(), r);
        endfunction

        task report_mismatch(string what);
            $display("mismatch: %s", what);
            mismatch_count++;
        endtask

        task check_vertex(logic [15:0] tdata, logic [1:0] tuser);
            corner_result_t want;
            words_seen++;
            if (results_due.size() == 0)
            begin
                report_mismatch($sformatf("word %0d with nothing pending: tdata=%h tuser=%b",
                                          words_seen, tdata, tuser));
                return;
            end
            want = results_due.pop_front();
            if (tdata[11:0] !== want.vertex_number)
                report_mismatch($sformatf("word %0d vertex_number %h, want %h",
                                          words_seen, tdata[11:0], want.vertex_number));
            if (tdata[15:12] !== 4'd0)
                report_mismatch($sformatf("word %0d padding bits %b, want zero",
                                          words_seen, tdata[15:12]));
            if (tuser[0] !== want.is_new)
                report_mismatch($sformatf("word %0d is_new %b, want %b",
                                          words_seen, tuser[0], want.is_new));
            if (tuser[1] !== want.table_full)
                report_mismatch($sformatf("word %0d table_full %b, want %b",
                                          words_seen, tuser[1], want.table_full));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // position_index, texcoord_index, normal_index
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // vertex_number, zero padding
    logic [1:0]  m_axis_tuser;   // is_new, table_full

    vertex_map_scoreboard corner_sb;

    // Idle control: a quiet side never idles; a pending long hold makes the
    // receiver take one long stall after its next word.
    bit send_quiet;
    bit recv_quiet;
    bit long_hold_req;

    vertex_index_dedup_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int idle_draw(bit quiet);
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic key_t random_key();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    // Each index field at zero, all ones or random.
    function automatic key_t extreme_field_key();
        key_t k;
        int   f;
        k = random_key();
        for (f = 0; f < 3; f++)
        begin
            case ($urandom_range(0, 2))
                0: k[16*f +: 16] = 16'h0000;
                1: k[16*f +: 16] = 16'hFFFF;
                default: ;
            endcase
        end
        return k;
    endfunction

    // Searches for a triple whose probe chain starts at the given slot, so
    // that it collides with whatever already sits there.
    function automatic key_t key_with_home(int unsigned slot);
        key_t k;
        k = random_key();
        while (corner_sb.home_slot(k) != slot)
            k = random_key();
        return k;
    endfunction

    function automatic key_t known_key();
        return corner_sb.stored_keys[$urandom_range(0, corner_sb.stored_keys.size() - 1)];
    endfunction

    task automatic send_corner(key_t key);
        int gap;
        gap = idle_draw(send_quiet);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        do @(posedge clk); while (!s_axis_tready);
        corner_sb.note_corner(key);
    endtask

    // Random traffic: mostly repeats and fresh triples, plus near-misses that
    // differ from a stored key in one bit, extreme field values and keys that
    // land on an occupied home slot.
    task automatic send_mixed_corner();
        int   pick;
        key_t k;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            k = known_key();
        else if (pick < 80)
            k = random_key();
        else if (pick < 88)
            k = known_key() ^ (48'd1 << $urandom_range(0, 47));
        else if (pick < 95)
            k = extreme_field_key();
        else
            k = key_with_home(corner_sb.home_slot(known_key()));
        send_corner(k);
    endtask

    // Result side: random stalls between words, one long hold on request.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall         = LONG_HOLD;
            end
            else
            begin
                stall = idle_draw(recv_quiet);
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            corner_sb.check_vertex(m_axis_tdata, m_axis_tuser);
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        key_t wrap_keys [WRAP_CORNERS];
        int   i;
        int   drain;

        corner_sb     = new;
        send_quiet    = 1'b0;
        recv_quiet    = 1'b0;
        long_hold_req = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners. The block clears its table first; the first send
        // simply waits for tready.
        send_corner(48'h0000_0000_0000);
        send_corner(48'h0000_0000_0000);
        send_corner(48'hFFFF_FFFF_FFFF);
        send_corner(48'h0000_0000_FFFF);
        send_corner(48'h0000_FFFF_0000);
        send_corner(48'hFFFF_0000_0000);
        send_corner(48'h5555_5555_5555);
        send_corner(48'hAAAA_AAAA_AAAA);
        // One-bit differences in each field must not alias the all-zero key.
        send_corner(48'h0000_0000_0001);
        send_corner(48'h0000_0001_0000);
        send_corner(48'h0001_0000_0000);
        send_corner(48'hFFFF_FFFF_FFFF);
        // Three triples homed on the last slot: the probe chain wraps to 0.
        for (i = 0; i < WRAP_CORNERS; i++)
            wrap_keys[i] = key_with_home(TABLE_SLOTS - 1);
        for (i = 0; i < WRAP_CORNERS; i++)
            send_corner(wrap_keys[i]);
        for (i = WRAP_CORNERS - 1; i >= 0; i--)
            send_corner(wrap_keys[i]);
        send_corner(48'h0000_0000_0000);

        // Random part. Around the middle the receiver holds off for a long
        // stretch while the sender keeps pushing, so the block backs up.
        for (i = 0; i < RANDOM_CORNERS; i++)
        begin
            if (i % 60 == 0)
            begin
                send_quiet = ($urandom_range(0, 3) == 0);
                recv_quiet = ($urandom_range(0, 3) == 0);
            end
            if (i == RANDOM_CORNERS / 2)
            begin
                long_hold_req = 1'b1;
                send_quiet    = 1'b1;
            end
            send_mixed_corner();
        end

        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (corner_sb.results_due.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        // Any stray word still arriving shows up as an unexpected result.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (corner_sb.results_due.size() != 0)
            corner_sb.report_mismatch($sformatf("%0d results never arrived",
                                                corner_sb.results_due.size()));
        if (corner_sb.mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
